// ===== rtl/lge_pkg.sv =====
// Shared types and constants for the life grid engine.
package lge_pkg;

   typedef enum logic [1:0] {
      CMD_TOGGLE = 2'd0,
      CMD_STEP   = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_READ   = 2'd3
   } lge_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_PASS,
      ST_DONE
   } lge_state_type;

   // Control broadcast from the sequencer to every row cell.
   typedef struct packed {
      logic shift;       // sweep advances one column
      logic clear;       // kill the whole row
      logic first;       // sweep is at column 0
      logic last;        // sweep is at the last column
      logic step;        // write next generation
      logic toggle_col;  // toggle command and sweep is at the addressed column
   } lge_ctrl_type;

   localparam logic [3:0] LIFE_KEEP = 4'd2;
   localparam logic [3:0] LIFE_BORN = 4'd3;

endpackage

// ===== rtl/lge_row_cell.sv =====
// One grid row: a rotating register that evaluates one column per cycle while the sweep shifts.
module lge_row_cell #(
   parameter int GRID_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lge_pkg::lge_ctrl_type ctrl,
   input  logic                 sel,
   input  logic [2:0]           up_win,
   input  logic [2:0]           dn_win,
   output logic [2:0]           win,
   output logic [3:0]           cnt,
   output logic                 new_bit
);
   import lge_pkg::*;

   logic [GRID_WIDTH-1:0] row_ff;
   logic                  prev_ff;
   logic                  first_ff;
   logic                  left;
   logic                  center;
   logic                  right;

   // The ring rotates right once per column, so the current column sits at bit 0.
   // Already written columns wrap to the top, so the old values of the left
   // neighbor and of column 0 are kept aside.
   assign center = row_ff[0];
   assign left   = ctrl.first ? row_ff[GRID_WIDTH-1] : prev_ff;
   assign right  = ctrl.last ? first_ff : row_ff[1];
   assign win    = {left, center, right};

   assign cnt = {3'b000, up_win[0]} + {3'b000, up_win[1]} + {3'b000, up_win[2]}
              + {3'b000, dn_win[0]} + {3'b000, dn_win[1]} + {3'b000, dn_win[2]}
              + {3'b000, left} + {3'b000, right};

   always_comb begin
      if (ctrl.step) begin
         new_bit = center ? ((cnt == LIFE_KEEP) || (cnt == LIFE_BORN)) : (cnt == LIFE_BORN);
      end else if (ctrl.toggle_col && sel) begin
         new_bit = ~center;
      end else begin
         new_bit = center;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         row_ff <= '0;
      end else if (ctrl.shift) begin
         row_ff <= {new_bit, row_ff[GRID_WIDTH-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         prev_ff <= center;
         if (ctrl.first) begin
            first_ff <= center;
         end
      end
   end

endmodule

// ===== rtl/life_grid_engine_unit.sv =====
// Game of Life (B3/S23) engine on a GRID_HEIGHT x GRID_WIDTH torus, held in a ring
// of row cells. Toggle, step and read each sweep the grid once, one column per
// cycle in every row at the same time; clear wipes all rows at once without a
// sweep. An address beyond the grid is reduced first by repeated subtraction of
// GRID_HEIGHT from the row or GRID_WIDTH from the column, both being reduced in
// the same cycles. The result sits in an output register, so a new command is
// accepted while the previous result waits.
module life_grid_engine_unit #(
   parameter int GRID_HEIGHT = 32,
   parameter int GRID_WIDTH  = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [4:0] req_cell_row,
   input  logic [4:0] req_cell_col,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_cell_alive,
   output logic [3:0] rsp_neighbor_count
);
   import lge_pkg::*;

   localparam int RW = $clog2(GRID_HEIGHT);
   localparam int CW = $clog2(GRID_WIDTH);
   localparam int RA = (RW > 5) ? RW : 5;
   localparam int CA = (CW > 5) ? CW : 5;

   lge_state_type state_ff, state_in;
   lge_cmd_type   cmd_ff;
   lge_ctrl_type  ctrl;
   logic [RA-1:0] row_ff;
   logic [CA-1:0] col_ff;
   logic [CW-1:0] col_cnt_ff;
   logic          res_alive_ff;
   logic [3:0]    res_cnt_ff;
   logic          rsp_valid_ff;
   logic          rsp_alive_ff;
   logic [3:0]    rsp_cnt_ff;
   logic          load_rsp;
   logic          row_over;
   logic          col_over;
   logic          last_col;
   logic          col_hit;
   logic          req_take;

   logic [2:0] win_arr [GRID_HEIGHT];
   logic [3:0] cnt_arr [GRID_HEIGHT];
   logic       new_arr [GRID_HEIGHT];

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign row_over  = (int'(row_ff) >= GRID_HEIGHT);
   assign col_over  = (int'(col_ff) >= GRID_WIDTH);
   assign last_col  = (col_cnt_ff == CW'(GRID_WIDTH - 1));
   assign col_hit   = (col_cnt_ff == col_ff[CW-1:0]);

   for (genvar r = 0; r < GRID_HEIGHT; r++) begin : g_row
      lge_row_cell #(
         .GRID_WIDTH (GRID_WIDTH)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .sel     (row_ff[RW-1:0] == RW'(r)),
         .up_win  (win_arr[(r + GRID_HEIGHT - 1) % GRID_HEIGHT]),
         .dn_win  (win_arr[(r + 1) % GRID_HEIGHT]),
         .win     (win_arr[r]),
         .cnt     (cnt_arr[r]),
         .new_bit (new_arr[r])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      load_rsp = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (!row_over && !col_over) begin
               if (cmd_ff == CMD_CLEAR) begin
                  ctrl.clear = 1'b1;
                  state_in   = ST_DONE;
               end else begin
                  state_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            ctrl.shift      = 1'b1;
            ctrl.first      = (col_cnt_ff == '0);
            ctrl.last       = last_col;
            ctrl.step       = (cmd_ff == CMD_STEP);
            ctrl.toggle_col = col_hit && (cmd_ff == CMD_TOGGLE);
            if (last_col) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Address reduction modulo the grid size, one subtraction per cycle.
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff <= lge_cmd_type'(req_cmd);
         row_ff <= RA'(req_cell_row);
         col_ff <= CA'(req_cell_col);
      end else if (state_ff == ST_REDUCE) begin
         if (row_over) begin
            row_ff <= row_ff - RA'(GRID_HEIGHT);
         end
         if (col_over) begin
            col_ff <= col_ff - CA'(GRID_WIDTH);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_REDUCE) begin
         col_cnt_ff <= '0;
      end else if (state_ff == ST_PASS) begin
         col_cnt_ff <= col_cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         res_alive_ff <= 1'b0;
         res_cnt_ff   <= '0;
      end else if ((state_ff == ST_PASS) && col_hit) begin
         res_alive_ff <= new_arr[row_ff[RW-1:0]];
         res_cnt_ff   <= (cmd_ff == CMD_STEP) ? 4'd0 : cnt_arr[row_ff[RW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_alive_ff <= res_alive_ff;
         rsp_cnt_ff   <= res_cnt_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_alive     = rsp_alive_ff;
   assign rsp_neighbor_count = rsp_cnt_ff;

`ifndef SYNTHESIS
   a_take_starts_reduce: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_REDUCE))
      else $error("accepted transaction did not start address reduction");

   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PASS) && last_col) |=> (state_ff == ST_DONE))
      else $error("column sweep overran the last column");

   a_addr_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PASS) |-> (!row_over && !col_over))
      else $error("sweep running with an unreduced address");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside the completion state");

   a_zero_count: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && ((cmd_ff == CMD_STEP) || (cmd_ff == CMD_CLEAR)))
      |-> (rsp_cnt_ff == 4'd0))
      else $error("nonzero neighbor count for step or clear");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the life grid engine: directed table, then random commands.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lge_pkg::*;

   localparam int ROWS = 32;
   localparam int COLS = 32;
   localparam int RANDOM_ITEMS = 560;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 80;

   typedef struct packed {
      lge_cmd_type cmd;
      logic [4:0]  row;
      logic [4:0]  col;
      logic        fixed;   // expected result typed in below
      logic        alive;
      logic [3:0]  count;
   } stim_row_type;

   typedef struct packed {
      logic       alive;
      logic [3:0] count;
   } cell_report_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_cmd = CMD_READ;
   logic [4:0] req_cell_row = '0;
   logic [4:0] req_cell_col = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_cell_alive;
   logic [3:0] rsp_neighbor_count;

   // side-band copy of the typed-in expectation, driven with the transaction
   logic       req_fixed = 1'b0;
   logic       req_fix_alive = 1'b0;
   logic [3:0] req_fix_count = '0;

   bit              life_cells [ROWS][COLS];
   cell_report_type pending_reports [$];
   int              accepted_count = 0;
   int              error_count = 0;
   logic            hold_rsp = 1'b0;
   logic            calm;

   stim_row_type directed_rows [24] = '{
      '{CMD_READ,   5'd0,  5'd0,  1'b1, 1'b0, 4'd0},
      '{CMD_READ,   5'd31, 5'd31, 1'b1, 1'b0, 4'd0},
      '{CMD_TOGGLE, 5'd0,  5'd0,  1'b1, 1'b1, 4'd0},
      '{CMD_TOGGLE, 5'd0,  5'd0,  1'b1, 1'b0, 4'd0},
      // vertical blinker across the top/bottom seam
      '{CMD_TOGGLE, 5'd31, 5'd5,  1'b0, 1'b0, 4'd0},
      '{CMD_TOGGLE, 5'd0,  5'd5,  1'b0, 1'b0, 4'd0},
      '{CMD_TOGGLE, 5'd1,  5'd5,  1'b0, 1'b0, 4'd0},
      '{CMD_READ,   5'd0,  5'd5,  1'b0, 1'b0, 4'd0},
      '{CMD_STEP,   5'd0,  5'd5,  1'b0, 1'b0, 4'd0},
      '{CMD_READ,   5'd0,  5'd4,  1'b0, 1'b0, 4'd0},
      '{CMD_READ,   5'd0,  5'd6,  1'b0, 1'b0, 4'd0},
      '{CMD_STEP,   5'd31, 5'd31, 1'b0, 1'b0, 4'd0},
      '{CMD_CLEAR,  5'd0,  5'd5,  1'b1, 1'b0, 4'd0},
      '{CMD_READ,   5'd0,  5'd5,  1'b1, 1'b0, 4'd0},
      // ring of eight around a cell on the left/right seam
      '{CMD_TOGGLE, 5'd14, 5'd30, 1'b0, 1'b0, 4'd0},
      '{CMD_TOGGLE, 5'd14, 5'd31, 1'b0, 1'b0, 4'd0},
      '{CMD_TOGGLE, 5'd14, 5'd0,  1'b0, 1'b0, 4'd0},
      '{CMD_TOGGLE, 5'd15, 5'd30, 1'b0, 1'b0, 4'd0},
      '{CMD_TOGGLE, 5'd15, 5'd0,  1'b0, 1'b0, 4'd0},
      '{CMD_TOGGLE, 5'd16, 5'd30, 1'b0, 1'b0, 4'd0},
      '{CMD_TOGGLE, 5'd16, 5'd31, 1'b0, 1'b0, 4'd0},
      '{CMD_TOGGLE, 5'd16, 5'd0,  1'b0, 1'b0, 4'd0},
      '{CMD_READ,   5'd15, 5'd31, 1'b1, 1'b0, 4'd8},
      '{CMD_STEP,   5'd15, 5'd31, 1'b0, 1'b0, 4'd0}
   };

   life_grid_engine_unit #(
      .GRID_HEIGHT(ROWS),
      .GRID_WIDTH(COLS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_cell_row(req_cell_row),
      .req_cell_col(req_cell_col),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_cell_alive(rsp_cell_alive),
      .rsp_neighbor_count(rsp_neighbor_count)
   );

   always #2 clock = ~clock;

   assign calm = (accepted_count >= 300) && (accepted_count < 400);

   function automatic logic [3:0] live_neighbors(int r, int c);
      int n = 0;
      for (int dr = -1; dr <= 1; dr++)
         for (int dc = -1; dc <= 1; dc++)
            if (dr != 0 || dc != 0)
               n += life_cells[(r + dr + ROWS) % ROWS][(c + dc + COLS) % COLS];
      return n[3:0];
   endfunction

   function automatic cell_report_type predict_command(logic [1:0] cmd, logic [4:0] row,
                                                       logic [4:0] col);
      bit              next_gen [ROWS][COLS];
      cell_report_type rep;
      int              r;
      int              c;
      int              n;
      r = row % ROWS;
      c = col % COLS;
      rep.count = '0;
      case (cmd)
         CMD_TOGGLE: begin
            life_cells[r][c] = ~life_cells[r][c];
            rep.count = live_neighbors(r, c);
         end
         CMD_STEP: begin
            for (int i = 0; i < ROWS; i++)
               for (int j = 0; j < COLS; j++) begin
                  n = live_neighbors(i, j);
                  next_gen[i][j] = life_cells[i][j] ? (n == 2 || n == 3) : (n == 3);
               end
            life_cells = next_gen;
         end
         CMD_CLEAR: begin
            for (int i = 0; i < ROWS; i++)
               for (int j = 0; j < COLS; j++)
                  life_cells[i][j] = 1'b0;
         end
         default: begin
            rep.count = live_neighbors(r, c);
         end
      endcase
      rep.alive = life_cells[r][c];
      return rep;
   endfunction

   // request side: predict on every accepted transaction
   always @(posedge clock) begin
      cell_report_type rep;
      if (!reset && req_valid && !req_stall) begin
         rep = predict_command(req_cmd, req_cell_row, req_cell_col);
         if (req_fixed) begin
            rep.alive = req_fix_alive;
            rep.count = req_fix_count;
         end
         pending_reports.push_back(rep);
         accepted_count <= accepted_count + 1;
      end
   end

   // response side: compare against the oldest expectation
   always @(posedge clock) begin
      cell_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $error("unexpected result: cell_alive=%0d neighbor_count=%0d",
                   rsp_cell_alive, rsp_neighbor_count);
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_cell_alive !== want.alive) begin
               $error("cell_alive: expected %0d, got %0d", want.alive, rsp_cell_alive);
               error_count++;
            end
            if (rsp_neighbor_count !== want.count) begin
               $error("neighbor_count: expected %0d, got %0d", want.count,
                      rsp_neighbor_count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_rsp)
         rsp_stall <= 1'b1;
      else if (calm)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < 18);
   end

   // long receiver hold-off so the result register fills and the input backs up
   initial begin
      wait (accepted_count >= 150);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   task automatic send_command(stim_row_type s);
      if (!calm && $urandom_range(0, 99) < 18) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= s.cmd;
      req_cell_row  <= s.row;
      req_cell_col  <= s.col;
      req_fixed     <= s.fixed;
      req_fix_alive <= s.alive;
      req_fix_count <= s.count;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      stim_row_type item;
      int           pick;
      logic [4:0]   base_r;
      logic [4:0]   base_c;
      base_r = '0;
      base_c = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_command(directed_rows[i]);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // most activity lands in a small patch so patterns form and evolve
         if (i % 40 == 0) begin
            base_r = 5'($urandom_range(0, 31));
            base_c = 5'($urandom_range(0, 31));
         end
         pick = $urandom_range(0, 99);
         item.fixed = 1'b0;
         item.alive = 1'b0;
         item.count = '0;
         if (pick < 40)
            item.cmd = CMD_TOGGLE;
         else if (pick < 72)
            item.cmd = CMD_READ;
         else if (pick < 97)
            item.cmd = CMD_STEP;
         else
            item.cmd = CMD_CLEAR;
         if ($urandom_range(0, 3) == 0) begin
            item.row = 5'($urandom_range(0, 31));
            item.col = 5'($urandom_range(0, 31));
         end else begin
            item.row = base_r + 5'($urandom_range(0, 5));
            item.col = base_c + 5'($urandom_range(0, 5));
         end
         send_command(item);
      end
      req_valid <= 1'b0;
      // let the predictor queue the last accepted transaction
      @(posedge clock);

      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_reports.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
